FILE: hdl/bounded_stack_with_max_query_core_macros.svh
// Assertion macros shared by the stack RTL.
// Depends on nothing; taken in by `include inside module bodies.
`ifndef BOUNDED_STACK_WITH_MAX_QUERY_CORE_MACROS_SVH
`define BOUNDED_STACK_WITH_MAX_QUERY_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BSMQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack assertion failed");

// Next-cycle implication, disabled while reset is held.
`define BSMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack assertion failed");

`endif

FILE: hdl/bsmq_pkg.sv
// Package for the bounded stack: field widths, types, operation and status codes.
// Depends on nothing.
`default_nettype none

package bsmq_pkg;

    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 4;
    localparam int DEPTH_DEFAULT = 8;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [STATUS_W-1:0]      t_status;
    typedef logic [FILL_W-1:0]        t_fill;

    // Operation codes.
    localparam t_op OP_PUSH = 3'd0;
    localparam t_op OP_POP  = 3'd1;
    localparam t_op OP_PEEK = 3'd2;
    localparam t_op OP_MAX  = 3'd3;
    localparam t_op OP_DUMP = 3'd4;

    // Status codes.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;

endpackage

`default_nettype wire

FILE: hdl/bsmq_if.sv
// Valid/ready channel interfaces for the stack: command in, response out.
// Depends on bsmq_pkg.
`default_nettype none

interface bsmq_cmd_if;
    logic             valid;
    logic             ready;
    bsmq_pkg::t_op    operation;
    bsmq_pkg::t_data  push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface bsmq_rsp_if;
    logic              valid;
    logic              ready;
    bsmq_pkg::t_data   data;
    bsmq_pkg::t_status status;
    bsmq_pkg::t_fill   fill_level;
    logic              last;

    modport source (output valid, output data, output status, output fill_level,
                    output last, input ready);
    modport sink   (input valid, input data, input status, input fill_level,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/bsmq_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
// Depends on nothing.
`default_nettype none

module bsmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/bounded_stack_with_max_query_core.sv
// Bounded LIFO stack of signed 32-bit words with pop, peek, maximum and dump.
// Commands arrive on i_cmd (operation, push_value); results leave on o_rsp
// (data, status, fill_level, last), both valid/ready channels.
// One command is handled at a time: i_cmd.ready is high only while the
// sequencer is idle. The entries sit in a single RAM with one registered read
// port, and that port sets the order of steps:
//   push, unknown operation or any error: the result goes from S_EMIT to the output.
//   pop and peek: one RAM read, captured in S_FETCH, then S_EMIT.
//   max: the entries are read from the bottom up in S_MAX, one entry compared per cycle.
//   dump: count results from the top down, one a cycle while the receiver takes them.
// Every command ends with a result carrying last = 1.
// A finished result sits in an output register, so a new command is accepted
// while it waits; a stalled receiver holds the sequencer only when it has the
// next result ready. Reset empties the stack and drops any pending result;
// the entries themselves are not cleared.
// Depends on bsmq_pkg, bsmq_if, bsmq_ram and the assertion macro header.
`default_nettype none

module bounded_stack_with_max_query_core #(
    parameter int DEPTH = bsmq_pkg::DEPTH_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bsmq_cmd_if.sink   i_cmd,
    bsmq_rsp_if.source o_rsp
);

    import bsmq_pkg::*;
    `include "bounded_stack_with_max_query_core_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EMIT  = 3'd2;
    localparam logic [2:0] S_MAX   = 3'd3;
    localparam logic [2:0] S_DUMP  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    t_data         r_res_data, n_res_data;
    t_status       r_res_status, n_res_status;

    logic          r_out_valid;
    t_data         r_out_data;
    t_status       r_out_status;
    t_fill         r_out_fill;
    logic          r_out_last;

    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_data         rd_data;
    logic          load;
    t_data         ld_data;
    t_status       ld_status;
    logic          ld_last;

    logic          accept;
    logic          out_free;
    logic          full;
    logic          empty;
    logic [AW-1:0] top_idx;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign top_idx  = AW'(r_count - CW'(1));

    assign i_cmd.ready = (r_state == S_IDLE);

    // Entry storage.
    bsmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_count)),
        .i_wr_data (i_cmd.push_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer: decodes a command, walks the RAM and hands results to the output register.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        load         = 1'b0;
        ld_data      = r_res_data;
        ld_status    = r_res_status;
        ld_last      = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_data   = '0;
                    n_res_status = ST_OK;
                    n_state      = S_EMIT;
                    case (i_cmd.operation)
                        OP_PUSH: begin
                            if (full) begin
                                n_res_status = ST_OVERFLOW;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                rd_en   = 1'b1;
                                rd_addr = top_idx;
                                n_state = S_FETCH;
                            end
                        end
                        OP_PEEK: begin
                            if (empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = top_idx;
                                n_state = S_FETCH;
                            end
                        end
                        OP_MAX: begin
                            if (empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                n_idx   = '0;
                                n_state = S_MAX;
                            end
                        end
                        OP_DUMP: begin
                            if (empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = top_idx;
                                n_idx   = top_idx;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            n_res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_res_data = rd_data;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MAX: begin
                // One entry per cycle: compare the word read last cycle, fetch the next.
                if ((r_idx == '0) || (rd_data > r_res_data)) begin
                    n_res_data = rd_data;
                end
                if (r_idx == top_idx) begin
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + AW'(1);
                    n_idx   = r_idx + AW'(1);
                end
            end
            S_DUMP: begin
                // Hand out the entry last read from the RAM, then fetch the one below it.
                if (out_free) begin
                    load      = 1'b1;
                    ld_data   = rd_data;
                    ld_status = ST_OK;
                    ld_last   = (r_idx == '0);
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - AW'(1);
                        n_idx   = r_idx - AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
    end

    // Output register: loaded when free, emptied when the receiver takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_data   <= ld_data;
            r_out_status <= ld_status;
            r_out_fill   <= FILL_W'(r_count);
            r_out_last   <= ld_last;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.data       = r_out_data;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.fill_level = r_out_fill;
    assign o_rsp.last       = r_out_last;

    // Checks on the sequencer and the fill count.
    `BSMQ_ASSERT_NOW(a_count_bounded, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `BSMQ_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n,
        accept && (i_cmd.operation == OP_PUSH) && !full, r_count == $past(r_count) + CW'(1))
    `BSMQ_ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n, load && ld_last, r_state == S_IDLE)
    `BSMQ_ASSERT_NOW(a_walk_in_range, i_clk, i_rst_n,
        (r_state == S_MAX) || (r_state == S_DUMP), CW'(r_idx) < r_count)

endmodule

`default_nettype wire
